// ----- rtl/core/ibc_pkg.sv -----
package ibc_pkg;

  // Sample and store geometry.
  localparam int SAMPLE_W      = 10;
  localparam int LOG2_LUMA     = 15;
  localparam int MAX_BLOCK_W   = 64;
  localparam int ROW_CAP       = 64;
  localparam int BLK_CAP       = (MAX_BLOCK_W < ROW_CAP) ? MAX_BLOCK_W : ROW_CAP;
  localparam int LOG2_CTU_MIN  = 5;
  localparam int LOG2_CTU_MAX  = 7;
  localparam int LOG2_BLK_MIN  = 2;
  localparam int LOG2_BLK_MAX  = 6;

  // Luma takes the lower half of the address space, Cb and Cr share the third quarter.
  localparam int STORE_DEPTH   = 3 << (LOG2_LUMA - 1);
  localparam int ADDR_W        = LOG2_LUMA + 1;
  localparam int XW            = LOG2_LUMA - LOG2_CTU_MIN;
  localparam int ROW_W         = LOG2_CTU_MAX;
  localparam int COL_W         = 6;
  localparam int CNT_W         = COL_W + 1;
  localparam int SHIFT_W       = $clog2(LOG2_LUMA + 1);

  // Request and component codes.
  localparam logic       REQ_WRITE = 1'b0;
  localparam logic       REQ_COPY  = 1'b1;
  localparam logic [1:0] COMP_Y    = 2'd0;
  localparam logic [1:0] COMP_CB   = 2'd1;
  localparam logic [1:0] COMP_CR   = 2'd2;
  localparam logic [1:0] COMP_NONE = 2'd3;

  typedef struct packed {
    logic                req_type;
    logic [1:0]          comp;
    logic [9:0]          ctb_col;
    logic [6:0]          pos_x;
    logic [6:0]          pos_y;
    logic [2:0]          log2_width;
    logic [2:0]          log2_height;
    logic [5:0]          row;
    logic [13:0]         mv_x;
    logic [13:0]         mv_y;
    logic [SAMPLE_W-1:0] sample_in;
  } in_item_t;

  typedef struct packed {
    logic                rd;
    logic                wr;
    logic [ADDR_W-1:0]   addr;
    logic [SAMPLE_W-1:0] wdata;
  } store_req_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [COL_W-1:0]    column;
    logic                last;
  } out_item_t;

  typedef struct packed {
    logic [1:0] count;
    logic       pop;
  } fifo_stat_t;

  // Maps a component, a row and a column to a word of the shared sample memory.
  function automatic logic [ADDR_W-1:0] store_addr(input logic [1:0]         comp,
                                                    input logic [SHIFT_W-1:0] lbw,
                                                    input logic [ROW_W-1:0]   r,
                                                    input logic [XW-1:0]      x);
    logic [LOG2_LUMA-1:0] idx;
    logic [ADDR_W-1:0]    a;
    idx = (LOG2_LUMA'(r) << lbw) | LOG2_LUMA'(x);
    case (comp)
      COMP_CB: a = {2'b10, 1'b0, idx[LOG2_LUMA-3:0]};
      COMP_CR: a = {2'b10, 1'b1, idx[LOG2_LUMA-3:0]};
      default: a = {1'b0, idx};
    endcase
    return a;
  endfunction

endpackage

// ----- rtl/core/ibc_store.sv -----
module ibc_store
  import ibc_pkg::*;
(
  input  logic                clk,
  input  store_req_t          req,
  output logic [SAMPLE_W-1:0] rdata
);

  logic [SAMPLE_W-1:0] mem [0:STORE_DEPTH-1];

  // Single port sample memory with a registered read.
  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

// ----- rtl/core/ibc_out_fifo.sv -----
module ibc_out_fifo
  import ibc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  out_item_t           push_item,
  output fifo_stat_t          stat,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [SAMPLE_W-1:0] sample_out,
  output logic [COL_W-1:0]    column,
  output logic                last
);

  out_item_t  slots [0:1];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign out_valid  = (count != 2'd0);
  assign pop        = out_valid && !out_stall;
  assign stat.count = count;
  assign stat.pop   = pop;
  assign sample_out = slots[rd_ptr].sample;
  assign column     = slots[rd_ptr].column;
  assign last       = slots[rd_ptr].last;

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  // Item storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

// ----- rtl/core/ibc_copy_ctrl.sv -----
module ibc_copy_ctrl
  import ibc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic [2:0]          ctu_log2,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_item_t            in_item,
  output store_req_t          req,
  input  logic [SAMPLE_W-1:0] rdata,
  input  fifo_stat_t          stat,
  output logic                push,
  output out_item_t           push_item
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SETUP = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;
  localparam logic [1:0] ST_WRITE = 2'd3;

  logic [1:0]          state;
  in_item_t            f;

  // Per-row geometry, held for the read and write sweeps.
  logic [1:0]          comp_q;
  logic [SHIFT_W-1:0]  lbw;
  logic [XW-1:0]       bwmask_q;
  logic [ROW_W-1:0]    src_row;
  logic [ROW_W-1:0]    dst_row;
  logic [XW-1:0]       src_x0;
  logic [XW-1:0]       dst_x0;
  logic [CNT_W-1:0]    cnt;

  // Sweep counters.
  logic [CNT_W-1:0]    rd_i;
  logic                rd_pend;
  logic [COL_W-1:0]    rd_col;
  logic                rd_last;
  logic [CNT_W-1:0]    wr_i;
  logic                wb_pend;
  logic [COL_W-1:0]    wb_col;
  logic [SAMPLE_W-1:0] rb_q;
  logic [SAMPLE_W-1:0] rowbuf [0:(1 << COL_W)-1];

  // Setup arithmetic.
  logic [2:0]           l;
  logic                 sh;
  logic [SHIFT_W-1:0]   lbw_y;
  logic [SHIFT_W-1:0]   lbw_c;
  logic [XW-1:0]        wmask;
  logic [XW-1:0]        bwmask;
  logic [ROW_W-1:0]     cmask;
  logic [ROW_W-1:0]     bhmask;
  logic [4:0]           two_l;
  logic [4:0]           nshift;
  logic [LOG2_LUMA-1:0] p_full;
  logic [XW-1:0]        p;
  logic [XW-1:0]        cp;
  logic [XW-1:0]        wx;
  logic [ROW_W-1:0]     wy;
  logic [LOG2_LUMA-1:0] sum_x;
  logic [XW-1:0]        ref_x;
  logic [ROW_W-1:0]     ref_y;
  logic [2:0]           lh;
  logic [2:0]           lw;
  logic [COL_W-1:0]     hmask;
  logic [COL_W-1:0]     rowm;
  logic [CNT_W-1:0]     wfull;
  logic [CNT_W-1:0]     wcap;

  logic                 space_ok;
  logic                 rd_issue;
  logic                 wb_issue;
  logic                 in_accept;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  // Geometry of the registered item against the current CTU size.
  always_comb begin
    if (ctu_log2 < 3'(LOG2_CTU_MIN)) begin
      l = 3'(LOG2_CTU_MIN);
    end else if (ctu_log2 > 3'(LOG2_CTU_MAX)) begin
      l = 3'(LOG2_CTU_MAX);
    end else begin
      l = ctu_log2;
    end
    sh     = (f.comp != COMP_Y);
    lbw_y  = SHIFT_W'(LOG2_LUMA) - SHIFT_W'(l);
    lbw_c  = lbw_y - SHIFT_W'(sh);
    wmask  = XW'((LOG2_LUMA'(1) << lbw_y) - LOG2_LUMA'(1));
    bwmask = wmask >> sh;
    cmask  = ROW_W'((LOG2_LUMA'(1) << l) - LOG2_LUMA'(1));
    bhmask = cmask >> sh;

    // Column of the current CTU inside the buffer; zero when the buffer holds under one CTU.
    two_l  = {1'b0, l, 1'b0};
    nshift = 5'(LOG2_LUMA) - two_l;
    if (5'(LOG2_LUMA) >= two_l) begin
      p_full = (LOG2_LUMA'(f.ctb_col) & ((LOG2_LUMA'(1) << nshift) - LOG2_LUMA'(1))) << l;
    end else begin
      p_full = '0;
    end
    p  = XW'(p_full);
    cp = p >> sh;

    // Write target.
    wx = (cp + XW'(f.pos_x)) & bwmask;
    wy = ROW_W'(f.pos_y) & bhmask;

    // Copy source.
    sum_x = LOG2_LUMA'(p) + LOG2_LUMA'(f.pos_x) + LOG2_LUMA'($signed(f.mv_x));
    ref_x = (XW'(sum_x) & wmask) >> sh;
    ref_y = (ROW_W'(LOG2_LUMA'(f.pos_y) + LOG2_LUMA'($signed(f.mv_y))) & cmask) >> sh;

    if (f.log2_height < 3'(LOG2_BLK_MIN)) begin
      lh = 3'(LOG2_BLK_MIN);
    end else if (f.log2_height > 3'(LOG2_BLK_MAX)) begin
      lh = 3'(LOG2_BLK_MAX);
    end else begin
      lh = f.log2_height;
    end
    if (f.log2_width < 3'(LOG2_BLK_MIN)) begin
      lw = 3'(LOG2_BLK_MIN);
    end else if (f.log2_width > 3'(LOG2_BLK_MAX)) begin
      lw = 3'(LOG2_BLK_MAX);
    end else begin
      lw = f.log2_width;
    end
    hmask = COL_W'(((CNT_W'(1) << lh) >> sh) - CNT_W'(1));
    rowm  = f.row & hmask;
    wfull = CNT_W'(1) << lw;
    wcap  = (wfull > CNT_W'(BLK_CAP)) ? CNT_W'(BLK_CAP) : wfull;
  end

  // Read issue keeps the output queue from overflowing, counting the read in flight.
  assign space_ok = (3'(stat.count) - 3'(stat.pop) + 3'(rd_pend)) <= 3'd1;
  assign rd_issue = (state == ST_READ) && (rd_i < cnt) && space_ok;
  assign wb_issue = (state == ST_WRITE) && (wr_i < cnt);

  // Memory request: sample write, source read or destination write-back.
  always_comb begin
    req = '0;
    if (state == ST_SETUP && f.req_type == REQ_WRITE && f.comp != COMP_NONE) begin
      req.wr    = 1'b1;
      req.addr  = store_addr(f.comp, lbw_c, wy, wx);
      req.wdata = f.sample_in;
    end else if (rd_issue) begin
      req.rd   = 1'b1;
      req.addr = store_addr(comp_q, lbw, src_row, (src_x0 + XW'(rd_i)) & bwmask_q);
    end else if (wb_pend) begin
      req.wr    = 1'b1;
      req.addr  = store_addr(comp_q, lbw, dst_row, (dst_x0 + XW'(wb_col)) & bwmask_q);
      req.wdata = rb_q;
    end
  end

  // Each source sample goes out as soon as it is read.
  assign push             = rd_pend;
  assign push_item.sample = rdata;
  assign push_item.column = rd_col;
  assign push_item.last   = rd_last;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      rd_pend <= 1'b0;
      wb_pend <= 1'b0;
      rd_i    <= '0;
      wr_i    <= '0;
    end else begin
      rd_pend <= rd_issue;
      wb_pend <= wb_issue;
      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            state <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          rd_i <= '0;
          wr_i <= '0;
          if (f.req_type == REQ_COPY && f.comp != COMP_NONE) begin
            state <= ST_READ;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_READ: begin
          if (rd_issue) begin
            rd_i <= rd_i + CNT_W'(1);
          end
          if (rd_i == cnt && !rd_pend) begin
            state <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          if (wb_issue) begin
            wr_i <= wr_i + CNT_W'(1);
          end
          if (wr_i == cnt && !wb_pend) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Item fields and row geometry.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      f <= in_item;
    end
    if (state == ST_SETUP) begin
      comp_q   <= f.comp;
      lbw      <= lbw_c;
      bwmask_q <= bwmask;
      src_row  <= (ref_y + ROW_W'(rowm)) & bhmask;
      dst_row  <= ((ROW_W'(f.pos_y) >> sh) + ROW_W'(rowm)) & bhmask;
      src_x0   <= ref_x;
      dst_x0   <= cp + XW'(f.pos_x >> sh);
      cnt      <= wcap >> sh;
    end
    if (rd_issue) begin
      rd_col  <= rd_i[COL_W-1:0];
      rd_last <= (rd_i == cnt - CNT_W'(1));
    end
    if (wb_issue) begin
      wb_col <= wr_i[COL_W-1:0];
    end
  end

  // Row buffer: filled during the read sweep, drained during the write-back.
  always_ff @(posedge clk) begin
    if (rd_pend) begin
      rowbuf[rd_col] <= rdata;
    end
    if (wb_issue) begin
      rb_q <= rowbuf[wr_i[COL_W-1:0]];
    end
  end

  // The output queue never receives an item while full and not draining.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !(stat.count == 2'd2 && !stat.pop))
    else $error("output queue overflow");

  // The memory port never reads and writes in the same cycle.
  a_one_access: assert property (@(posedge clk) disable iff (rst)
    !(req.rd && req.wr))
    else $error("read and write on the memory port together");

  // Write-back only starts once every source read has landed in the row buffer.
  a_reads_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE) |-> (!rd_pend && rd_i == cnt))
    else $error("write-back before the read sweep finished");

  // An accepted item is always set up in the next cycle.
  a_setup: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state == ST_SETUP))
    else $error("accepted item not set up");

endmodule

// ----- rtl/core/ibc_reference_buffer_copy.sv -----
// Intra-block-copy reference buffer for luma and 4:2:0 chroma.
// Input channel (in_valid / in_stall): a write item stores one reconstructed sample; a copy
// item moves one row of a block from its block-vector source to the current CTU and emits the
// copied samples on the output channel (out_valid / out_stall), one item per sample with its
// column and a last flag on the final sample of the row.
// Configuration (cfg_valid / cfg_ready / log2_ctu_size) sets the CTU size; it is always ready.
// The user must write it only while the block is idle; the block does not enforce this.
// A write item only passes the set-up state. A copy item of w samples (w up to 64,
// halved for chroma) goes through the set-up state, a read sweep through the single port sample
// memory, then a write-back sweep from the row buffer to the destination. The first sample
// passes the set-up state, the registered memory read and the output queue before it appears.
// A new item is taken as soon as the write-back finishes, while results may still wait.
// Stalling the output pauses the read sweep once the two-entry output queue is full; nothing
// is lost. Reset clears the sequencer and the queue and sets the CTU size to 128; the sample
// memory is not cleared and must be written before it is read.
module ibc_reference_buffer_copy
  import ibc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          log2_ctu_size,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                req_type,
  input  logic [1:0]          comp,
  input  logic [9:0]          ctb_col,
  input  logic [6:0]          pos_x,
  input  logic [6:0]          pos_y,
  input  logic [2:0]          log2_width,
  input  logic [2:0]          log2_height,
  input  logic [5:0]          row,
  input  logic signed [13:0]  mv_x,
  input  logic signed [13:0]  mv_y,
  input  logic [9:0]          sample_in,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [9:0]          sample_out,
  output logic [5:0]          column,
  output logic                last
);

  logic [2:0]          ctu_log2;
  in_item_t            in_item;
  store_req_t          req;
  logic [SAMPLE_W-1:0] rdata;
  fifo_stat_t          stat;
  logic                push;
  out_item_t           push_item;

  assign cfg_ready = 1'b1;

  // CTU size register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctu_log2 <= 3'(LOG2_CTU_MAX);
    end else if (cfg_valid && cfg_ready) begin
      ctu_log2 <= log2_ctu_size;
    end
  end

  assign in_item.req_type    = req_type;
  assign in_item.comp        = comp;
  assign in_item.ctb_col     = ctb_col;
  assign in_item.pos_x       = pos_x;
  assign in_item.pos_y       = pos_y;
  assign in_item.log2_width  = log2_width;
  assign in_item.log2_height = log2_height;
  assign in_item.row         = row;
  assign in_item.mv_x        = mv_x;
  assign in_item.mv_y        = mv_y;
  assign in_item.sample_in   = sample_in;

  ibc_copy_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .ctu_log2  (ctu_log2),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .req       (req),
    .rdata     (rdata),
    .stat      (stat),
    .push      (push),
    .push_item (push_item)
  );

  ibc_store u_store (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  ibc_out_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out),
    .column     (column),
    .last       (last)
  );

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import ibc_pkg::*;

  localparam int LUMA_ENTRIES   = 1 << LOG2_LUMA;
  localparam int CHROMA_ENTRIES = LUMA_ENTRIES / 4;
  localparam int SETTLE_CYCLES  = 2 * BLK_CAP + 20;
  localparam int RANDOM_OPS     = 130;
  localparam int TIMEOUT_NS     = 10_000_000;

  typedef int idx_list_t [BLK_CAP];

  // Buffer layout for one component under the current CTU size.
  typedef struct {
    int lctu;
    int luma_w;
    int ctu_h;
    int nctu;
    int base;
    int sh;
    int bw;
    int bh;
    int cp;
  } geom_t;

  logic               clk           = 1'b0;
  logic               rst           = 1'b1;
  logic               cfg_valid     = 1'b0;
  logic               cfg_ready;
  logic [2:0]         log2_ctu_size = 3'd7;
  logic               in_valid      = 1'b0;
  logic               in_stall;
  logic               req_type      = REQ_WRITE;
  logic [1:0]         comp          = COMP_Y;
  logic [9:0]         ctb_col       = '0;
  logic [6:0]         pos_x         = '0;
  logic [6:0]         pos_y         = '0;
  logic [2:0]         log2_width    = 3'd2;
  logic [2:0]         log2_height   = 3'd2;
  logic [5:0]         row           = '0;
  logic signed [13:0] mv_x          = '0;
  logic signed [13:0] mv_y          = '0;
  logic [9:0]         sample_in     = '0;
  logic               out_valid;
  logic               out_stall     = 1'b0;
  logic [9:0]         sample_out;
  logic [5:0]         column;
  logic               last;

  // Mirror of the block: CTU size register, sample stores and which entries hold data.
  logic [2:0]          ctu_cfg = 3'd7;
  logic [SAMPLE_W-1:0] sample_mem [3][LUMA_ENTRIES];
  bit                  written [3][LUMA_ENTRIES];
  out_item_t           expected_samples [$];
  out_item_t           want;

  int  error_count     = 0;
  int  items_sent      = 0;
  int  copies_sent     = 0;
  int  samples_checked = 0;
  int  stall_left      = 0;
  bit  calm            = 1'b0;

  ibc_reference_buffer_copy u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .log2_ctu_size (log2_ctu_size),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .comp          (comp),
    .ctb_col       (ctb_col),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .log2_width    (log2_width),
    .log2_height   (log2_height),
    .row           (row),
    .mv_x          (mv_x),
    .mv_y          (mv_y),
    .sample_in     (sample_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .sample_out    (sample_out),
    .column        (column),
    .last          (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic geom_t buffer_geometry(input logic [1:0] c, input logic [9:0] ctb);
    geom_t g;
    g.lctu   = (ctu_cfg < LOG2_CTU_MIN) ? LOG2_CTU_MIN :
               ((ctu_cfg > LOG2_CTU_MAX) ? LOG2_CTU_MAX : int'(ctu_cfg));
    g.luma_w = LUMA_ENTRIES >> g.lctu;
    g.ctu_h  = 1 << g.lctu;
    g.nctu   = g.luma_w >> g.lctu;
    g.base   = (g.nctu == 0) ? 0 : ((int'(ctb) & (g.nctu - 1)) << g.lctu);
    g.sh     = (c == COMP_Y) ? 0 : 1;
    g.bw     = g.luma_w >> g.sh;
    g.bh     = g.ctu_h >> g.sh;
    g.cp     = g.base >> g.sh;
    return g;
  endfunction

  function automatic int clamp_log2(input logic [2:0] v);
    return (v < LOG2_BLK_MIN) ? LOG2_BLK_MIN : ((v > LOG2_BLK_MAX) ? LOG2_BLK_MAX : int'(v));
  endfunction

  function automatic int write_index(input in_item_t it);
    geom_t g;
    g = buffer_geometry(it.comp, it.ctb_col);
    return (int'(it.pos_y) & (g.bh - 1)) * g.bw + ((g.cp + int'(it.pos_x)) & (g.bw - 1));
  endfunction

  // Source and destination entries of one copied row; returns the row width.
  function automatic int plan_copy(input in_item_t it, output idx_list_t src,
                                   output idx_list_t dst);
    geom_t g;
    int    w, h, r, mvx, mvy, ref_x, ref_y, src_row, dst_row;
    g   = buffer_geometry(it.comp, it.ctb_col);
    w   = 1 << clamp_log2(it.log2_width);
    if (w > BLK_CAP) begin
      w = BLK_CAP;
    end
    w   = w >> g.sh;
    h   = (1 << clamp_log2(it.log2_height)) >> g.sh;
    r   = int'(it.row) & (h - 1);
    mvx = int'($signed(it.mv_x));
    mvy = int'($signed(it.mv_y));
    ref_x   = ((g.base + int'(it.pos_x) + mvx) & (g.luma_w - 1)) >> g.sh;
    ref_y   = ((int'(it.pos_y) + mvy) & (g.ctu_h - 1)) >> g.sh;
    src_row = (ref_y + r) & (g.bh - 1);
    dst_row = ((int'(it.pos_y) >> g.sh) + r) & (g.bh - 1);
    for (int i = 0; i < BLK_CAP; i++) begin
      src[i] = src_row * g.bw + ((ref_x + i) & (g.bw - 1));
      dst[i] = dst_row * g.bw + ((g.cp + (int'(it.pos_x) >> g.sh) + i) & (g.bw - 1));
    end
    return w;
  endfunction

  // Applies one accepted item to the mirror and queues the samples that it copies.
  function automatic void store_and_copy(input in_item_t it);
    idx_list_t           src, dst;
    logic [SAMPLE_W-1:0] held [BLK_CAP];
    out_item_t           res;
    int                  w, idx;
    if (it.comp == COMP_NONE) begin
      return;
    end
    if (it.req_type == REQ_WRITE) begin
      idx = write_index(it);
      sample_mem[it.comp][idx] = it.sample_in;
      written[it.comp][idx]    = 1'b1;
      return;
    end
    w = plan_copy(it, src, dst);
    // The whole source row is read before any destination entry changes.
    for (int i = 0; i < w; i++) begin
      held[i] = sample_mem[it.comp][src[i]];
    end
    for (int i = 0; i < w; i++) begin
      sample_mem[it.comp][dst[i]] = held[i];
      written[it.comp][dst[i]]    = 1'b1;
      res.sample = held[i];
      res.column = 6'(i);
      res.last   = (i == w - 1);
      expected_samples.push_back(res);
    end
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    it.req_type    = 1'($urandom);
    it.comp        = 2'($urandom);
    it.ctb_col     = 10'($urandom);
    it.pos_x       = 7'($urandom);
    it.pos_y       = 7'($urandom);
    it.log2_width  = 3'($urandom);
    it.log2_height = 3'($urandom);
    it.row         = 6'($urandom);
    it.mv_x        = 14'($urandom);
    it.mv_y        = 14'($urandom);
    it.sample_in   = 10'($urandom);
    return it;
  endfunction

  // Builds a write item that lands on a given store entry, with random don't-care fields.
  function automatic in_item_t write_to(input logic [1:0] c, input int idx,
                                        input logic [9:0] value);
    in_item_t it;
    geom_t    g;
    int       r, x, sub, ctb;
    g   = buffer_geometry(c, '0);
    r   = idx / g.bw;
    x   = idx % g.bw;
    sub = g.lctu - g.sh;
    ctb = x >> sub;
    it  = random_item();
    it.req_type  = REQ_WRITE;
    it.comp      = c;
    it.ctb_col   = 10'(ctb + g.nctu * $urandom_range(0, (1023 - ctb) / g.nctu));
    it.pos_x     = 7'(x & ((1 << sub) - 1));
    it.pos_y     = 7'(r + g.bh * $urandom_range(0, (127 - r) / g.bh));
    it.sample_in = value;
    return it;
  endfunction

  function automatic in_item_t random_write();
    logic [1:0] c;
    c = 2'($urandom_range(0, 2));
    return write_to(c, $urandom_range(0, (c == COMP_Y) ? LUMA_ENTRIES - 1 : CHROMA_ENTRIES - 1),
                    10'($urandom));
  endfunction

  function automatic in_item_t copy_item(input logic [1:0] c, input int ctb, px, py, lw, lh,
                                         r, mvx, mvy);
    in_item_t it;
    it = random_item();
    it.req_type    = REQ_COPY;
    it.comp        = c;
    it.ctb_col     = 10'(ctb);
    it.pos_x       = 7'(px);
    it.pos_y       = 7'(py);
    it.log2_width  = 3'(lw);
    it.log2_height = 3'(lh);
    it.row         = 6'(r);
    it.mv_x        = 14'(mvx);
    it.mv_y        = 14'(mvy);
    return it;
  endfunction

  // Mostly narrow rows, short vectors half of the time, and full-range fields otherwise.
  function automatic in_item_t random_copy();
    in_item_t it;
    it = random_item();
    it.req_type = REQ_COPY;
    it.comp     = 2'($urandom_range(0, 2));
    if ($urandom_range(0, 3) != 0) begin
      it.log2_width = 3'($urandom_range(2, 4));
    end
    if ($urandom_range(0, 1) == 0) begin
      it.mv_x = 14'($urandom_range(0, 64) - 32);
      it.mv_y = 14'($urandom_range(0, 64) - 32);
    end
    return it;
  endfunction

  // Offers one item, with an occasional idle burst first, and waits until it is taken.
  task automatic send_item(input in_item_t it);
    int gap;
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= it.req_type;
    comp        <= it.comp;
    ctb_col     <= it.ctb_col;
    pos_x       <= it.pos_x;
    pos_y       <= it.pos_y;
    log2_width  <= it.log2_width;
    log2_height <= it.log2_height;
    row         <= it.row;
    mv_x        <= it.mv_x;
    mv_y        <= it.mv_y;
    sample_in   <= it.sample_in;
    do @(posedge clk); while (in_stall);
    store_and_copy(it);
    items_sent++;
  endtask

  // Writes every source entry of a copy that holds no data yet, so nothing undefined is read.
  task automatic fill_sources(input in_item_t it);
    idx_list_t src, dst;
    int        w;
    w = plan_copy(it, src, dst);
    for (int i = 0; i < w; i++) begin
      if (!written[it.comp][src[i]]) begin
        send_item(write_to(it.comp, src[i], 10'($urandom)));
      end
    end
  endtask

  task automatic copy_row(input in_item_t it);
    fill_sources(it);
    send_item(it);
    copies_sent++;
  endtask

  // Lets every queued sample arrive, then gives the block time to finish a trailing write.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_samples.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_ctu_size(input logic [2:0] value);
    wait_drained();
    cfg_valid     <= 1'b1;
    log2_ctu_size <= value;
    do @(posedge clk); while (!cfg_ready);
    ctu_cfg = value;
    cfg_valid <= 1'b0;
  endtask

  // Single sample writes at the first and last luma and Cb entries and the last Cr entry.
  task automatic test_sample_writes();
    send_item(write_to(COMP_Y, 0, '0));
    send_item(write_to(COMP_Y, LUMA_ENTRIES - 1, '1));
    send_item(write_to(COMP_CB, 0, 10'h2AA));
    send_item(write_to(COMP_CB, CHROMA_ENTRIES - 1, 10'h155));
    send_item(write_to(COMP_CR, CHROMA_ENTRIES - 1, '1));
  endtask

  // Copies at the edges of the field ranges and of the buffer.
  task automatic test_copy_corners();
    // Full width luma row copied onto itself.
    copy_row(copy_item(COMP_Y, 0, 0, 0, 6, 6, 0, 0, 0));
    // Most negative vector, oversized width, undersized height and a wrapping row.
    copy_row(copy_item(COMP_Y, 1023, 127, 127, 7, 0, 63, -8192, -8192));
    // Chroma row whose source and destination both run past the right edge.
    copy_row(copy_item(COMP_CB, 1023, 127, 127, 6, 7, 63, 8191, 8191));
    // Smallest chroma block.
    copy_row(copy_item(COMP_CR, 0, 0, 0, 0, 1, 1, -4, 0));
    // Source overlaps the destination within the same row, then a chroma copy with a vertical offset.
    copy_row(copy_item(COMP_Y, 5, 32, 16, 4, 3, 2, 4, 0));
    copy_row(copy_item(COMP_CR, 512, 96, 40, 5, 5, 17, -3, 8));
  endtask

  // Items for the unused component code must leave the stores alone and copy nothing.
  task automatic test_ignored_component();
    in_item_t  target, bogus;
    idx_list_t src, dst;
    target = copy_item(COMP_Y, 3, 20, 10, 3, 2, 1, -40, 5);
    fill_sources(target);
    void'(plan_copy(target, src, dst));
    bogus = write_to(COMP_Y, src[0], ~sample_mem[COMP_Y][src[0]]);
    bogus.comp = COMP_NONE;
    send_item(bogus);
    bogus.req_type = REQ_COPY;
    send_item(bogus);
    copy_row(target);
  endtask

  // Every CTU size, including register values outside the legal range.
  task automatic test_ctu_sizes();
    logic [2:0] sizes [6] = '{3'd5, 3'd0, 3'd6, 3'd4, 3'd7, 3'd1};
    foreach (sizes[k]) begin
      set_ctu_size(sizes[k]);
      repeat (3) copy_row(random_copy());
      send_item(random_write());
    end
  endtask

  // Mixed traffic in four CTU size phases; the final phase runs without any idling.
  task automatic test_random_traffic();
    in_item_t it;
    int       pick;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n % 33 == 0) begin
        if (n >= 99) begin
          calm = 1'b1;
        end
        set_ctu_size(3'($urandom_range(0, 7)));
      end
      pick = $urandom_range(0, 19);
      if (pick < 13) begin
        copy_row(random_copy());
      end else if (pick < 18) begin
        send_item(random_write());
      end else begin
        it = random_item();
        it.comp = COMP_NONE;
        send_item(it);
      end
    end
  endtask

  // Output stall in random bursts.
  always @(posedge clk) begin
    if (rst || calm) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left = $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Each sample taken from the block is compared with the oldest one queued.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_samples.size() == 0) begin
        error_count++;
        $display("%0t: unexpected item: expected none, got sample %0d column %0d last %0d",
                 $time, sample_out, column, last);
      end else begin
        want = expected_samples.pop_front();
        samples_checked++;
        if (sample_out !== want.sample) begin
          error_count++;
          $display("%0t: sample_out mismatch: expected %0d, got %0d",
                   $time, want.sample, sample_out);
        end
        if (column !== want.column) begin
          error_count++;
          $display("%0t: column mismatch: expected %0d, got %0d", $time, want.column, column);
        end
        if (last !== want.last) begin
          error_count++;
          $display("%0t: last mismatch: expected %0d, got %0d", $time, want.last, last);
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_sample_writes();
    test_copy_corners();
    test_ignored_component();
    test_ctu_sizes();
    test_random_traffic();
    wait_drained();
    $display("Sent %0d items, %0d of them row copies, over CTU sizes 32 to 128.",
             items_sent, copies_sent);
    $display("Compared %0d copied samples and found %0d mismatches.",
             samples_checked, error_count);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
